@@ src/abkf_pkg.sv @@
// Package for the angle/bias Kalman filter: sequencer states and widths.
// Used by every module in src; depends on nothing.
package abkf_pkg;
	localparam int unsigned CmdSetAngle = 1;
	localparam logic signed [31:0] SMax = 32'sh7fffffff;
	localparam logic signed [31:0] SMin = -32'sh80000000;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RATE, ST_ANG_M, ST_ANG, ST_P11DT, ST_INNER, ST_P00,
		ST_P11Q, ST_DIV0, ST_DIVW0, ST_DIV1, ST_DIVW1, ST_Y, ST_A_M, ST_A,
		ST_B_M, ST_C00_M, ST_C01_M, ST_C10_M, ST_C11_M, ST_DONE, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] num;
		logic signed [63:0] den;
	} div_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [95:0] x);
		if (x > 96'(SMax)) return SMax;
		if (x < 96'(SMin)) return SMin;
		return x[31:0];
	endfunction
endpackage

@@ src/abkf_div.sv @@
// Shared signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on abkf_pkg.
module abkf_div import abkf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  div_req_t req,
	output logic busy,
	output logic signed [63:0] quot
);
	logic [63:0] rem_q, num_q, den_q, quo_q;
	logic neg_q;
	logic [6:0] cnt_q;
	logic [64:0] trial;

	assign trial = {rem_q, num_q[63]} - {1'b0, den_q};
	assign busy = cnt_q != 7'd0;
	assign quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 7'd64;
			num_q <= req.num[63] ? 64'(-req.num) : req.num;
			den_q <= req.den[63] ? 64'(-req.den) : req.den;
			neg_q <= req.num[63] ^ req.den[63];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
			num_q <= {num_q[62:0], 1'b0};
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], num_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

@@ src/angle_bias_kalman_filter.sv @@
// Top level of the angle/bias Kalman filter: sequencer, shared multiplier,
// state registers. Depends on abkf_pkg and abkf_div.
//
// One beat in gives one beat out. A set-angle beat goes from idle straight to
// the output state, so out_valid rises in the cycle after the beat is accepted.
// A filter beat steps through the states from ST_RATE to ST_DONE before ST_OUT,
// and the next beat of either kind can be taken once out_ready has taken the
// result. Two passes of the shared restoring divider take most of the time of a
// filter beat, each pass followed by a wait state until the divider is done.
// Ten products run through the one 33x35 multiplier, and each sum and
// saturation is registered in a sequencer state. When S is zero the divider is
// skipped and its wait states pass at once. in_ready is low while a beat is in
// work or its result waits. Configuration writes land whenever cfg_we is high,
// so write only while the block is idle.
module angle_bias_kalman_filter import abkf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [30:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic cmd,
	input  logic signed [31:0] measured_angle,
	input  logic signed [31:0] gyro_rate,
	input  logic [23:0] time_step,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] filtered_angle,
	output logic signed [31:0] unbiased_rate
);
	state_t state_q, state_d;
	logic [30:0] qa_q, qb_q, rm_q;
	logic signed [31:0] ang_q, bias_q, rate_q, c00_q, c01_q, c10_q, c11_q;
	logic signed [31:0] meas_q, gyro_q, p00_q, p01_q, p10_q, p11_q, y_q;
	logic signed [31:0] k0_q, k1_q;
	logic [23:0] dt_q;
	logic signed [63:0] inner_q, prod_q;
	logic signed [32:0] m_a;
	logic signed [34:0] m_b;
	logic signed [63:0] m_p;
	div_req_t dreq;
	logic dbusy;
	logic signed [63:0] dquot;
	logic signed [63:0] s_w;
	logic signed [95:0] rnd24, rnd28;

	abkf_div u_div (.clk, .arst_n, .req(dreq), .busy(dbusy), .quot(dquot));

	// One multiplier: operands picked by state, product registered.
	// The operands are 33 and 35 bits; the extension only sets the signed context.
	// The inner term of the angle variance needs up to 35 bits, hence the b side.
	assign m_p = 64'(m_a) * 64'(m_b);
	assign rnd24 = 96'(prod_q + 64'sd8388608) >>> 24;
	assign rnd28 = 96'(prod_q + 64'sd134217728) >>> 28;
	assign s_w = 64'(p00_q) + 64'($signed({1'b0, rm_q}));

	always_comb begin
		m_a = {9'd0, dt_q};
		m_b = 35'(rate_q);
		case (state_q)
			ST_ANG_M: m_b = 35'(rate_q);
			ST_P11DT: m_b = 35'(c11_q);
			ST_P00:   m_b = 35'(inner_q);
			ST_P11Q:  m_b = {4'd0, qb_q};
			ST_A_M:   begin m_a = 33'(k0_q); m_b = 35'(y_q); end
			ST_B_M:   begin m_a = 33'(k1_q); m_b = 35'(y_q); end
			ST_C00_M: begin m_a = 33'(k0_q); m_b = 35'(p00_q); end
			ST_C01_M: begin m_a = 33'(k0_q); m_b = 35'(p01_q); end
			ST_C10_M: begin m_a = 33'(k1_q); m_b = 35'(p00_q); end
			ST_C11_M: begin m_a = 33'(k1_q); m_b = 35'(p01_q); end
			default: ;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;
	assign filtered_angle = ang_q;
	assign unbiased_rate = rate_q;

	always_comb begin
		state_d = state_q;
		dreq = '{start: 1'b0, num: 64'(p00_q) <<< 28, den: s_w};
		case (state_q)
			ST_IDLE: if (in_valid) state_d = (cmd == 1'(CmdSetAngle)) ? ST_OUT : ST_RATE;
			ST_RATE:  state_d = ST_ANG_M;
			ST_ANG_M: state_d = ST_ANG;
			ST_ANG:   state_d = ST_P11DT;
			ST_P11DT: state_d = ST_INNER;
			ST_INNER: state_d = ST_P00;
			ST_P00:   state_d = ST_P11Q;
			ST_P11Q:  state_d = ST_DIV0;
			ST_DIV0: begin
				dreq.start = s_w != 0;
				state_d = ST_DIVW0;
			end
			ST_DIVW0: if (!dbusy) state_d = ST_DIV1;
			ST_DIV1: begin
				dreq.start = s_w != 0;
				dreq.num = 64'(p10_q) <<< 28;
				state_d = ST_DIVW1;
			end
			ST_DIVW1: if (!dbusy) state_d = ST_Y;
			ST_Y:     state_d = ST_A_M;
			ST_A_M:   state_d = ST_A;
			ST_A:     state_d = ST_B_M;
			ST_B_M:   state_d = ST_C00_M;
			ST_C00_M: state_d = ST_C01_M;
			ST_C01_M: state_d = ST_C10_M;
			ST_C10_M: state_d = ST_C11_M;
			ST_C11_M: state_d = ST_DONE;
			ST_DONE:  state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			qa_q <= 31'd268435;
			qb_q <= 31'd805306;
			rm_q <= 31'd8053064;
			ang_q <= '0; bias_q <= '0; rate_q <= '0;
			c00_q <= '0; c01_q <= '0; c10_q <= '0; c11_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					2'd0: qa_q <= cfg_data;
					2'd1: qb_q <= cfg_data;
					2'd2: rm_q <= cfg_data;
					default: ;
				endcase
			end
			prod_q <= m_p;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					meas_q <= measured_angle;
					gyro_q <= gyro_rate;
					dt_q <= time_step;
					if (cmd == 1'(CmdSetAngle)) ang_q <= measured_angle;
				end
				ST_RATE: rate_q <= sat32(96'(gyro_q) - 96'(bias_q));
				ST_ANG: ang_q <= sat32(96'(ang_q) + rnd24);
				ST_P11DT: begin
					// prod_q not yet valid here; capture after the multiply
				end
				ST_INNER: begin
					p01_q <= sat32(96'(c01_q) - rnd24);
					p10_q <= sat32(96'(c10_q) - rnd24);
					inner_q <= 64'(rnd24) - 64'(c01_q) - 64'(c10_q)
						+ 64'($signed({1'b0, qa_q}));
					p11_q <= c11_q;
				end
				ST_P11Q: p00_q <= sat32(96'(c00_q) + rnd24);
				ST_DIV0: begin
					k0_q <= '0;
					p11_q <= sat32(96'(p11_q) + rnd24);
				end
				ST_DIVW0: if (!dbusy && s_w != 0) k0_q <= sat32(96'(dquot));
				ST_DIV1: k1_q <= '0;
				ST_DIVW1: if (!dbusy && s_w != 0) k1_q <= sat32(96'(dquot));
				ST_Y: y_q <= sat32(96'(meas_q) - 96'(ang_q));
				ST_A: ang_q <= sat32(96'(ang_q) + rnd28);
				ST_B_M: ;
				ST_C00_M: bias_q <= sat32(96'(bias_q) + rnd28);
				ST_C01_M: c00_q <= sat32(96'(p00_q) - rnd28);
				ST_C10_M: c01_q <= sat32(96'(p01_q) - rnd28);
				ST_C11_M: c10_q <= sat32(96'(p10_q) - rnd28);
				ST_DONE: c11_q <= sat32(96'(p11_q) - rnd28);
				default: ;
			endcase
		end
	end
endmodule

@@ verif/angle_bias_kalman_filter_test.sv @@
// Testbench for angle_bias_kalman_filter: directed table, then random beats,
// checked against an in-bench fixed-point Kalman predictor or, for directed rows that carry them, typed expectations.
// Depends on abkf_pkg and the angle_bias_kalman_filter RTL.
`timescale 1ns / 100ps

module angle_bias_kalman_filter_test import abkf_pkg::*; ();

	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_SET = 1'(CmdSetAngle);

	localparam logic [1:0] REG_Q_ANGLE = 2'd0;
	localparam logic [1:0] REG_Q_BIAS = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE = 2'd2;
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam logic [30:0] Q_ANGLE_RST = 31'd268435;
	localparam logic [30:0] Q_BIAS_RST = 31'd805306;
	localparam logic [30:0] R_MEAS_RST = 31'd8053064;
	localparam logic [30:0] REG_MAX = 31'h7fffffff;

	// Result drain after the last beat.
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES = 3000;

	typedef enum logic { ROW_BEAT, ROW_REG } row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic cmd;
		logic signed [31:0] meas;
		logic signed [31:0] gyro;
		logic [23:0] dt;
		logic has_exp;
		logic signed [31:0] exp_angle;
		logic signed [31:0] exp_rate;
		logic [1:0] reg_idx;
		logic [30:0] reg_val;
	} stim_row_t;

	typedef struct {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
	} angle_rate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = 1'b0;
	logic signed [31:0] measured_angle = '0;
	logic signed [31:0] gyro_rate = '0;
	logic [23:0] time_step = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] unbiased_rate;

	angle_bias_kalman_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.measured_angle(measured_angle),
		.gyro_rate(gyro_rate),
		.time_step(time_step),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered_angle(filtered_angle),
		.unbiased_rate(unbiased_rate)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the filter state and noise registers.
	longint kf_q_angle, kf_q_bias, kf_r_meas;
	logic signed [31:0] kf_angle, kf_bias, kf_rate;
	logic signed [31:0] kf_c00, kf_c01, kf_c10, kf_c11;

	angle_rate_t expected_beats[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 0;

	function automatic logic signed [31:0] clamp32(input longint x);
		if (x > 64'sh7fffffff) return 32'sh7fffffff;
		if (x < -64'sh80000000) return 32'sh80000000;
		return x[31:0];
	endfunction

	// Round half up, then floor-shift (>>> on a signed longint floors).
	function automatic longint round_shr(input longint x, input int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint scale_dt(input longint dt, input longint x);
		return round_shr(dt * x, 24);
	endfunction

	function automatic longint scale_gain(input longint k, input longint x);
		return round_shr(k * x, 28);
	endfunction

	function automatic longint kalman_gain(input longint num, input longint s);
		if (s == 0) return 0;
		return longint'(clamp32((num <<< 28) / s));
	endfunction

	// Advance the predictor by one accepted beat and return what it reports.
	function automatic angle_rate_t kalman_advance(input logic c, input logic signed [31:0] m,
			input logic signed [31:0] g, input logic [23:0] d);
		longint dt, p00, p01, p10, p11, inner, s, k0, k1, y;
		angle_rate_t r;
		dt = longint'(d);
		if (c == CMD_SET) begin
			kf_angle = m;
		end else begin
			kf_rate = clamp32(longint'(g) - longint'(kf_bias));
			kf_angle = clamp32(longint'(kf_angle) + scale_dt(dt, longint'(kf_rate)));
			p11 = longint'(kf_c11);
			inner = scale_dt(dt, p11) - longint'(kf_c01) - longint'(kf_c10) + kf_q_angle;
			p00 = longint'(clamp32(longint'(kf_c00) + scale_dt(dt, inner)));
			p01 = longint'(clamp32(longint'(kf_c01) - scale_dt(dt, p11)));
			p10 = longint'(clamp32(longint'(kf_c10) - scale_dt(dt, p11)));
			p11 = longint'(clamp32(p11 + scale_dt(dt, kf_q_bias)));
			s = p00 + kf_r_meas;
			k0 = kalman_gain(p00, s);
			k1 = kalman_gain(p10, s);
			y = longint'(clamp32(longint'(m) - longint'(kf_angle)));
			kf_angle = clamp32(longint'(kf_angle) + scale_gain(k0, y));
			kf_bias = clamp32(longint'(kf_bias) + scale_gain(k1, y));
			kf_c00 = clamp32(p00 - scale_gain(k0, p00));
			kf_c01 = clamp32(p01 - scale_gain(k0, p01));
			kf_c10 = clamp32(p10 - scale_gain(k1, p00));
			kf_c11 = clamp32(p11 - scale_gain(k1, p01));
		end
		r.angle = kf_angle;
		r.rate = kf_rate;
		return r;
	endfunction

	// Offer one beat and hold it until accepted; the caller decides on a gap.
	task automatic send_beat(input logic c, input logic signed [31:0] m,
			input logic signed [31:0] g, input logic [23:0] d,
			input logic has_exp, input angle_rate_t typed);
		angle_rate_t pred;
		in_valid <= 1'b1;
		cmd <= c;
		measured_angle <= m;
		gyro_rate <= g;
		time_step <= d;
		do @(posedge clk); while (!in_ready);
		pred = kalman_advance(c, m, g, d);
		expected_beats.push_back(has_exp ? typed : pred);
	endtask

	task automatic maybe_gap();
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Write a register only once the block has drained and settled.
	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_Q_ANGLE: kf_q_angle = longint'(val);
			REG_Q_BIAS: kf_q_bias = longint'(val);
			REG_MEAS_NOISE: kf_r_meas = longint'(val);
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [30:0] qa, input logic [30:0] qb, input logic [30:0] rm);
		write_reg(REG_Q_ANGLE, qa);
		write_reg(REG_Q_BIAS, qb);
		write_reg(REG_MEAS_NOISE, rm);
	endtask

	function automatic logic signed [31:0] rand_q16(input int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
			2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
		endcase
	endfunction

	function automatic logic [23:0] rand_dt();
		case ($urandom_range(9))
			0: return 24'($urandom);
			1: return $urandom_range(1) ? 24'hffffff : 24'h0;
			default: return 24'($urandom_range(16777, 335544));
		endcase
	endfunction

	task automatic random_run(input int count);
		logic c;
		angle_rate_t none;
		none = '{default: '0};
		for (int i = 0; i < count; i++) begin
			c = ($urandom_range(9) == 0) ? CMD_SET : CMD_FILTER;
			if (i == count / 2 && send_idle_pct == 0) hold_req = 1;
			send_beat(c, rand_q16($urandom_range(3)), rand_q16($urandom_range(3)),
				rand_dt(), 1'b0, none);
			maybe_gap();
		end
	endtask

	stim_row_t dir_tab[$];

	function automatic void add_beat(input logic c, input logic signed [31:0] m,
			input logic signed [31:0] g, input logic [23:0] d, input logic has_exp,
			input logic signed [31:0] ea, input logic signed [31:0] er);
		dir_tab.push_back('{ROW_BEAT, c, m, g, d, has_exp, ea, er, REG_SPARE, '0});
	endfunction

	function automatic void add_reg(input logic [1:0] idx, input logic [30:0] val);
		dir_tab.push_back('{ROW_REG, CMD_FILTER, '0, '0, '0, 1'b0, '0, '0, idx, val});
	endfunction

	// Receiver: random back-pressure, plus a long hold-off on each request.
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare every accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		angle_rate_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (filtered_angle !== e.angle) begin
					$error("filtered_angle expected %0d actual %0d", e.angle, filtered_angle);
					errors++;
				end
				if (unbiased_rate !== e.rate) begin
					$error("unbiased_rate expected %0d actual %0d", e.rate, unbiased_rate);
					errors++;
				end
			end
		end
	end

	initial begin
		angle_rate_t typed;
		kf_q_angle = longint'(Q_ANGLE_RST);
		kf_q_bias = longint'(Q_BIAS_RST);
		kf_r_meas = longint'(R_MEAS_RST);
		{kf_angle, kf_bias, kf_rate} = '0;
		{kf_c00, kf_c01, kf_c10, kf_c11} = '0;

		// Zero divisor: with the measurement noise at zero and covariance fresh
		// from reset, a zero time step keeps S at zero, so no correction lands.
		add_reg(REG_MEAS_NOISE, '0);
		add_beat(CMD_FILTER, 0, 0, 24'h0, 1, 0, 0);
		add_beat(CMD_FILTER, 32'sh7fffffff, 0, 24'h0, 1, 0, 0);
		add_beat(CMD_SET, 32'sh7fffffff, 32'sh80000000, 24'hffffff, 1, 32'sh7fffffff, 0);
		add_beat(CMD_FILTER, 32'sh80000000, 32'sh7fffffff, 24'hffffff, 0, 0, 0);
		add_beat(CMD_SET, 32'sh80000000, 0, 24'h0, 0, 0, 0);
		// Saturating noise terms push the covariance toward its rails.
		add_reg(REG_MEAS_NOISE, R_MEAS_RST);
		add_reg(REG_Q_ANGLE, REG_MAX);
		add_reg(REG_Q_BIAS, REG_MAX);
		add_beat(CMD_FILTER, 32'sh7fffffff, 32'sh80000000, 24'hffffff, 0, 0, 0);
		add_beat(CMD_FILTER, 32'sh80000000, 32'sh7fffffff, 24'h000001, 0, 0, 0);
		add_beat(CMD_FILTER, 0, 0, 24'h0, 0, 0, 0);
		add_beat(CMD_FILTER, 0, 0, 24'hffffff, 0, 0, 0);
		add_beat(CMD_FILTER, 0, 0, 24'hffffff, 0, 0, 0);
		add_beat(CMD_FILTER, 32'sh00640000, 32'sh00010000, 24'h004189, 0, 0, 0);
		add_reg(REG_Q_ANGLE, '0);
		add_reg(REG_Q_BIAS, '0);
		add_reg(REG_MEAS_NOISE, REG_MAX);
		add_beat(CMD_FILTER, 32'sh12345678, 32'shedcba988, 24'h800000, 0, 0, 0);
		add_beat(CMD_SET, 32'sh12345678, 0, 24'h0, 0, 0, 0);
		add_beat(CMD_FILTER, -32'sh00050000, 32'sh00200000, 24'h010000, 0, 0, 0);
		// The spare index must leave every register alone.
		add_reg(REG_SPARE, 31'h2aaaaaaa);
		add_beat(CMD_FILTER, 32'sh00140000, -32'sh00030000, 24'h020000, 0, 0, 0);
		add_reg(REG_Q_ANGLE, Q_ANGLE_RST);
		add_reg(REG_Q_BIAS, Q_BIAS_RST);
		add_reg(REG_MEAS_NOISE, R_MEAS_RST);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 71;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_REG) begin
				write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
			end else begin
				typed.angle = dir_tab[i].exp_angle;
				typed.rate = dir_tab[i].exp_rate;
				send_beat(dir_tab[i].cmd, dir_tab[i].meas, dir_tab[i].gyro, dir_tab[i].dt,
					dir_tab[i].has_exp, typed);
				maybe_gap();
			end
		end

		random_run(250);
		write_all(31'($urandom), 31'($urandom), 31'($urandom));
		random_run(250);

		// Swap idling: sender now mostly stalls, receiver mostly ready.
		write_all(REG_MAX, REG_MAX, REG_MAX);
		send_idle_pct = 71;
		recv_idle_pct = 23;
		random_run(250);
		write_all('0, '0, '0);
		random_run(250);

		// No idling; a long receiver hold-off lands halfway through each run.
		write_all(Q_ANGLE_RST, Q_BIAS_RST, R_MEAS_RST);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_run(250);
		write_all(31'($urandom_range(0, 1 << 24)), 31'($urandom_range(0, 1 << 24)),
			31'($urandom_range(0, 1 << 26)));
		random_run(250);

		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("angle_bias_kalman_filter_test passed");
		end else begin
			$display("angle_bias_kalman_filter_test failed");
		end
		$finish;
	end

	// Hard stop if the handshakes ever hang.
	initial begin
		#20_000_000;
		$display("angle_bias_kalman_filter_test failed");
		$finish;
	end
endmodule
